@@ hdl/adjt_pkg.sv @@
// shared types and codes of the adjacency table with degree count
package adjt_pkg;

    localparam int ID_W  = 6;
    localparam int OP_W  = 3;
    localparam int DEG_W = 6;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
    localparam logic [OP_W-1:0] OP_DEG   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] node;
        logic [ID_W-1:0] peer;
    } t_req;

    typedef struct packed {
        logic             connected;
        logic [DEG_W-1:0] degree;
        logic [ID_W-1:0]  neighbour;
        logic             neighbour_valid;
        logic             final_item;
    } t_rsp;

endpackage

@@ hdl/adjacency_table_with_degree.sv @@
// directed adjacency table with per-node degree count, rows and counts in one memory
// set, clear, query and degree read the row into a register, then register the result
// single-result ops take no new request until the row is read and written back
// list: one result per cycle from the held row while the output is not stalled
// reset: i_rst_n synchronous, active low; per-row valid flops make every row read as zero
// right away, so no clearing pass is needed
module adjacency_table_with_degree #(
    parameter int NODES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  adjt_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output adjt_pkg::t_rsp  o_out_data
);
    import adjt_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int MW = NODES + DEG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    // row memory: {degree, link row}
    logic [MW-1:0]    mem [NODES];
    logic [MW-1:0]    r_rdata;
    logic [NODES-1:0] r_vld;

    logic [1:0]       r_state, n_state;
    logic [OP_W-1:0]  r_op;
    logic [AW-1:0]    r_node;
    logic [AW-1:0]    r_peer;
    logic             r_node_ok;
    logic             r_peer_ok;
    logic             r_self;

    logic [NODES-1:0] r_row, n_row;
    logic [DEG_W-1:0] r_deg, n_deg;

    logic             r_out_valid;
    t_rsp             r_out, n_out;
    logic             out_load;
    logic             out_free;

    logic             accept;
    logic             wr_en;
    logic [NODES-1:0] row_rd;
    logic [DEG_W-1:0] deg_rd;
    logic [NODES-1:0] peer_bit;
    logic             hit;
    logic [NODES-1:0] new_row;
    logic [DEG_W-1:0] new_deg;
    logic [NODES-1:0] low_bit;
    logic [ID_W-1:0]  low_idx;
    logic             list_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= mem[i_in_data.node[AW-1:0]];
        end
        if (wr_en) begin
            mem[r_node] <= {new_deg, new_row};
        end
    end

    // rows never written read as empty
    always_comb begin
        row_rd = '0;
        deg_rd = '0;
        if (r_node_ok && r_vld[r_node]) begin
            row_rd = r_rdata[NODES-1:0];
            deg_rd = r_rdata[MW-1:NODES];
        end
        peer_bit         = '0;
        peer_bit[r_peer] = 1'b1;
        hit              = r_peer_ok && row_rd[r_peer];
    end

    always_comb begin
        new_row = row_rd;
        new_deg = deg_rd;
        wr_en   = 1'b0;
        if (r_state == S_READ && out_free && r_node_ok && r_peer_ok) begin
            if (r_op == OP_SET && !r_self && !hit) begin
                new_row = row_rd | peer_bit;
                new_deg = deg_rd + DEG_W'(1);
                wr_en   = 1'b1;
            end else if (r_op == OP_CLEAR && hit) begin
                new_row = row_rd & ~peer_bit;
                new_deg = deg_rd - DEG_W'(1);
                wr_en   = 1'b1;
            end
        end
    end

    // lowest pending neighbour of the held row
    always_comb begin
        low_bit = r_row & (~r_row + NODES'(1));
        low_idx = '0;
        for (int i = 0; i < NODES; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | ID_W'(i);
            end
        end
        list_last = ((r_row & ~low_bit) == '0);
    end

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_deg    = r_deg;
        out_load = 1'b0;
        n_out    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_op > OP_LIST) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out.degree     = new_deg;
                    n_out.final_item = 1'b1;
                    if (r_op == OP_LIST) begin
                        if (row_rd == '0) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_row   = row_rd;
                            n_deg   = deg_rd;
                            n_state = S_LIST;
                        end
                    end else begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (r_op != OP_DEG) begin
                            n_out.connected = r_peer_ok && new_row[r_peer];
                        end
                    end
                end
            end
            S_LIST: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    n_out.connected       = 1'b1;
                    n_out.degree          = r_deg;
                    n_out.neighbour       = low_idx;
                    n_out.neighbour_valid = 1'b1;
                    n_out.final_item      = list_last;
                    n_row                 = r_row & ~low_bit;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[r_node] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_deg <= n_deg;
        if (out_load) begin
            r_out <= n_out;
        end
        if (accept) begin
            r_op      <= i_in_data.operation;
            r_node    <= i_in_data.node[AW-1:0];
            r_peer    <= i_in_data.peer[AW-1:0];
            r_node_ok <= ({1'b0, i_in_data.node} < (ID_W+1)'(NODES));
            r_peer_ok <= ({1'b0, i_in_data.peer} < (ID_W+1)'(NODES));
            r_self    <= (i_in_data.node == i_in_data.peer);
        end
    end

endmodule

@@ tb/adjt_checker.sv @@
// checker for the adjacency table: tracks links and degrees, compares each result
`timescale 1ns / 100ps

module adjt_checker #(
    parameter int NODES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  adjt_pkg::t_req i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  adjt_pkg::t_rsp i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_rsp_count
);
    import adjt_pkg::*;

    localparam int PRINT_CAP = 100;

    logic [63:0]      link_row    [0:63];
    logic [DEG_W-1:0] node_degree [0:63];
    t_rsp             expected_rsp_q [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("check failed at %0t ns: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // append one expected result at the tail of the queue
    task automatic queue_expected(input t_rsp rsp);
        expected_rsp_q = {expected_rsp_q, rsp};
    endtask

    // update the link table for one request and queue the results it causes
    task automatic apply_request(input t_req req);
        logic             node_ok;
        logic             peer_ok;
        logic [63:0]      row_bits;
        logic [DEG_W-1:0] deg;
        t_rsp             rsp;
        int               idx;

        node_ok = req.node < NODES;
        peer_ok = req.peer < NODES;
        case (req.operation)
            OP_SET: begin
                if (node_ok && peer_ok && req.node != req.peer &&
                    !link_row[req.node][req.peer]) begin
                    link_row[req.node][req.peer] = 1'b1;
                    node_degree[req.node] = node_degree[req.node] + DEG_W'(1);
                end
            end
            OP_CLEAR: begin
                if (node_ok && peer_ok && link_row[req.node][req.peer]) begin
                    link_row[req.node][req.peer] = 1'b0;
                    node_degree[req.node] = node_degree[req.node] - DEG_W'(1);
                end
            end
            OP_QUERY, OP_DEG, OP_LIST: ;
            default: return;    // unused codes: no result, no change
        endcase

        row_bits = node_ok ? link_row[req.node] : '0;
        deg      = node_ok ? node_degree[req.node] : '0;
        rsp            = '0;
        rsp.degree     = deg;
        rsp.final_item = 1'b1;

        if (req.operation == OP_LIST) begin
            if (row_bits == '0) begin
                queue_expected(rsp);
            end else begin
                for (idx = 0; idx < 64; idx++) begin
                    if (row_bits[idx]) begin
                        rsp.connected       = 1'b1;
                        rsp.neighbour       = ID_W'(idx);
                        rsp.neighbour_valid = 1'b1;
                        rsp.final_item      = (row_bits >> idx) == 64'd1;
                        queue_expected(rsp);
                    end
                end
            end
        end else begin
            if (req.operation != OP_DEG) begin
                rsp.connected = peer_ok && row_bits[req.peer];
            end
            queue_expected(rsp);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        int   k;

        if (!i_rst_n) begin
            for (k = 0; k < 64; k++) begin
                link_row[k]    = '0;
                node_degree[k] = '0;
            end
            expected_rsp_q.delete();
            o_fail_count = 0;
            o_rsp_count  = 0;
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_out_valid && i_out_ready) begin
                o_rsp_count++;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, neighbour %0d",
                                              i_out_data.neighbour));
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_out_data.connected !== want.connected)
                        report_mismatch($sformatf("connected got %b want %b",
                                                  i_out_data.connected, want.connected));
                    if (i_out_data.degree !== want.degree)
                        report_mismatch($sformatf("degree got %0d want %0d",
                                                  i_out_data.degree, want.degree));
                    if (i_out_data.neighbour !== want.neighbour)
                        report_mismatch($sformatf("neighbour got %0d want %0d",
                                                  i_out_data.neighbour, want.neighbour));
                    if (i_out_data.neighbour_valid !== want.neighbour_valid)
                        report_mismatch($sformatf("neighbour_valid got %b want %b",
                                                  i_out_data.neighbour_valid,
                                                  want.neighbour_valid));
                    if (i_out_data.final_item !== want.final_item)
                        report_mismatch($sformatf("final_item got %b want %b",
                                                  i_out_data.final_item, want.final_item));
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_data);
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
// top of the adjacency table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import adjt_pkg::*;

    localparam int NODES          = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 85;
    localparam int HOT_NODES      = 6;
    localparam int FILL_NODE      = NODES - 1;
    localparam int OP_UNUSED_LO   = 5;
    localparam int OP_UNUSED_HI   = 7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_req in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_data;

    int fail_count;
    int pending;
    int rsp_count;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    always #2 clk = ~clk;

    adjacency_table_with_degree #(
        .NODES(NODES)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    adjt_checker #(
        .NODES(NODES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_rsp_count  (rsp_count)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    function automatic t_req make_req(input logic [OP_W-1:0] op, input int node,
                                      input int peer);
        t_req req;
        req.operation = op;
        req.node      = ID_W'(node);
        req.peer      = ID_W'(peer);
        return req;
    endfunction

    // mostly updates on a few hot nodes so rows fill up and lists get long
    function automatic t_req random_request();
        t_req req;
        int   pick;
        int   node;
        pick = $urandom_range(0, 99);
        if (pick < 40)      req.operation = OP_SET;
        else if (pick < 60) req.operation = OP_CLEAR;
        else if (pick < 72) req.operation = OP_QUERY;
        else if (pick < 82) req.operation = OP_DEG;
        else if (pick < 96) req.operation = OP_LIST;
        else                req.operation = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        node = ($urandom_range(0, 99) < 70) ? $urandom_range(0, HOT_NODES - 1)
                                            : $urandom_range(0, NODES - 1);
        req.node = ID_W'(node);
        req.peer = ($urandom_range(0, 19) == 0) ? ID_W'(node)
                                                : ID_W'($urandom_range(0, NODES - 1));
        return req;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_req(input t_req req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int u;
        int k;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, self link, repeated set, extreme ids, unused codes
        send_req(make_req(OP_QUERY, 0, 0));
        send_req(make_req(OP_DEG, 0, 0));
        send_req(make_req(OP_LIST, 0, 0));
        send_req(make_req(OP_SET, 0, 63));
        send_req(make_req(OP_SET, 0, 0));
        send_req(make_req(OP_SET, 0, 63));
        send_req(make_req(OP_SET, 0, 1));
        send_req(make_req(OP_SET, 63, 0));
        send_req(make_req(OP_SET, 63, 62));
        send_req(make_req(OP_QUERY, 0, 63));
        send_req(make_req(OP_QUERY, 63, 0));
        send_req(make_req(OP_QUERY, 63, 63));
        send_req(make_req(OP_DEG, 0, 42));
        send_req(make_req(OP_LIST, 0, 21));
        send_req(make_req(OP_LIST, 63, 0));
        send_req(make_req(OP_CLEAR, 0, 5));
        send_req(make_req(OP_CLEAR, 0, 63));
        send_req(make_req(OP_DEG, 0, 0));
        send_req(make_req(OP_LIST, 0, 0));
        for (u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++) begin
            send_req(make_req(OP_W'(u), 63, 63));
        end
        send_req(make_req(OP_CLEAR, 63, 0));
        send_req(make_req(OP_QUERY, 63, 0));
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_req(random_request());
            end
            if (phase == 1) begin
                // set every link of one row (the self link is also sent, and refused), then read it back
                for (k = NODES - 1; k >= 0; k--) begin
                    send_req(make_req(OP_SET, FILL_NODE, k));
                end
                send_req(make_req(OP_LIST, FILL_NODE, 0));
                send_req(make_req(OP_DEG, FILL_NODE, 0));
                send_req(make_req(OP_CLEAR, FILL_NODE, 31));
                send_req(make_req(OP_QUERY, FILL_NODE, 31));
                send_req(make_req(OP_LIST, FILL_NODE, 0));
            end
            // hold the next request back until every result is in
            drain_results();
        end

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d requests over four idle and stall phases and a full row",
                 sent_count);
        $display("%0d results compared, %0d still outstanding", rsp_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
